### design/satk_pkg.sv
package satk_pkg;

  typedef logic [30:0] score_t;

  typedef logic [1:0] op_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_COMMIT = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  localparam score_t SCORE_MAX = 31'h7FFF_FFFF;

  // Reciprocal of ten scaled by 2^35; exact quotient for any 32-bit value.
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP10_SHIFT = 35;

  typedef struct packed {
    logic   valid;
    logic   placed;
    score_t carry;
  } tok_t;

endpackage

### design/satk_cell.sv
module satk_cell #(
  parameter int PW = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  satk_pkg::tok_t   tin,
  input  logic [PW-1:0]    pos_in,
  output satk_pkg::tok_t   tout,
  output logic [PW-1:0]    pos_out,
  output satk_pkg::score_t entry
);

  logic swap;

  assign swap = tin.valid && (tin.placed || (tin.carry > entry));

  always_ff @(posedge clk) begin
    tout.carry  <= swap ? entry : tin.carry;
    tout.placed <= tin.placed || swap;
    pos_out     <= (tin.placed || swap) ? pos_in : pos_in + PW'(1);
    if (rst) begin
      entry      <= '0;
      tout.valid <= 1'b0;
    end else begin
      if (swap) begin
        entry <= tin.carry;
      end
      tout.valid <= tin.valid;
    end
  end

endmodule

### design/satk_digits.sv
module satk_digits #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  satk_pkg::score_t         value,
  output logic                     fin,
  output logic [4*DIGIT_COUNT-1:0] bcd
);

  localparam int CW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic             run;
  logic             phase;
  logic [CW-1:0]    cnt;
  satk_pkg::score_t v;
  logic [63:0]      prod;
  satk_pkg::score_t q;
  satk_pkg::score_t rem;

  assign q   = {2'b00, prod[63:satk_pkg::RECIP10_SHIFT]};
  assign rem = v - {q[27:0], 3'b000} - {q[29:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      fin   <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (go) begin
      run   <= 1'b1;
      fin   <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (run) begin
      phase <= ~phase;
      if (phase) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DIGIT_COUNT - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      v <= value;
    end else if (run) begin
      if (!phase) begin
        prod <= {1'b0, v} * satk_pkg::RECIP10;
      end else begin
        v <= q;
        bcd[4*cnt +: 4] <= rem[3:0];
      end
    end
  end

endmodule

### design/score_accumulate_and_topk_insert.sv
// Score accumulator with a descending top-K ranking table.
// A request is taken at a rising edge where start is high and busy is low;
// op selects add (add_value joins the running total, clamped to zero below
// and saturated at the 31-bit maximum), commit (the total is inserted before
// the first table entry it strictly exceeds) or read (entry_index selects
// one table entry). Every request gives exactly one result, shown for one
// cycle with done high: the total, its low DIGIT_COUNT decimal digits as
// packed BCD, the insert position for a commit (RANK_DEPTH when not placed)
// and the entry for a read.
// A commit result waits for both the digit unit and the row of table cells,
// any other result for the digit unit alone. Busy is low again in the done
// cycle, so the next request is taken at the edge that ends it, and no
// request is taken before the last one gives its result. The digit unit
// takes each digit as a reciprocal multiply followed by a remainder step,
// and a commit travels down the row of table cells one cell per cycle.
// The receiver cannot stall, so done is a plain strobe.
// Synchronous reset clears the total and every table entry to zero and
// returns the block to idle at the clock edge where reset is high.
module score_accumulate_and_topk_insert #(
  parameter int DIGIT_COUNT = 8,
  parameter int RANK_DEPTH  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [31:0] add_value,
  input  logic [2:0]         entry_index,
  output logic               done,
  output logic [30:0]        total_now,
  output logic [31:0]        digits_bcd,
  output logic [3:0]         rank_position,
  output logic [30:0]        entry_value
);

  localparam int PW = $clog2(RANK_DEPTH + 1);
  localparam int BW = 4 * DIGIT_COUNT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]              state;
  satk_pkg::op_t           op_r;
  logic signed [31:0]      value_r;
  logic [2:0]              index_r;
  satk_pkg::score_t        total_score;
  satk_pkg::score_t        total_next;
  logic signed [33:0]      sum;
  satk_pkg::score_t        read_val;
  satk_pkg::score_t        entry_r;
  logic                    cm_fin;
  logic                    finish;
  logic [PW-1:0]           pos_r;
  logic                    dig_go;
  logic                    dig_fin;
  logic [BW-1:0]           bcd;
  logic [BW+31:0]          bcd_ext;
  logic [PW+3:0]           pos_ext;

  satk_pkg::tok_t          tk  [RANK_DEPTH+1];
  logic [PW-1:0]           pos [RANK_DEPTH+1];
  satk_pkg::score_t        ent [RANK_DEPTH];

  assign busy = (state != ST_IDLE);

  assign sum = $signed({3'b000, total_score}) + $signed({{2{value_r[31]}}, value_r});

  always_comb begin
    total_next = total_score;
    if (op_r == satk_pkg::OP_ADD) begin
      if (sum <= 34'sd0) begin
        total_next = '0;
      end else if (sum > $signed({3'b000, satk_pkg::SCORE_MAX})) begin
        total_next = satk_pkg::SCORE_MAX;
      end else begin
        total_next = sum[30:0];
      end
    end
  end

  always_comb begin
    read_val = '0;
    for (int k = 0; k < RANK_DEPTH; k++) begin
      if ((k < 8) && (int'(index_r) == k)) begin
        read_val = ent[k];
      end
    end
  end

  assign tk[0] = '{valid:  (state == ST_EXEC) && (op_r == satk_pkg::OP_COMMIT),
                   placed: 1'b0,
                   carry:  total_score};
  assign pos[0] = '0;

  for (genvar g = 0; g < RANK_DEPTH; g++) begin : g_cell
    satk_cell #(
      .PW(PW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tin    (tk[g]),
      .pos_in (pos[g]),
      .tout   (tk[g+1]),
      .pos_out(pos[g+1]),
      .entry  (ent[g])
    );
  end

  assign dig_go = (state == ST_EXEC);

  satk_digits #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_digits (
    .clk  (clk),
    .rst  (rst),
    .go   (dig_go),
    .value(total_next),
    .fin  (dig_fin),
    .bcd  (bcd)
  );

  assign bcd_ext = {32'd0, bcd};
  assign pos_ext = {4'd0, pos_r};

  assign finish = (state == ST_WAIT) && dig_fin && (cm_fin || (op_r != satk_pkg::OP_COMMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      total_score <= '0;
      cm_fin      <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= finish;
      if (state == ST_EXEC) begin
        cm_fin <= 1'b0;
      end else if (tk[RANK_DEPTH].valid) begin
        cm_fin <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          total_score <= total_next;
          state       <= ST_WAIT;
        end
        ST_WAIT: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r    <= op;
      value_r <= add_value;
      index_r <= entry_index;
    end
    if (state == ST_EXEC) begin
      entry_r <= (op_r == satk_pkg::OP_READ) ? read_val : '0;
    end
    if (tk[RANK_DEPTH].valid) begin
      pos_r <= pos[RANK_DEPTH];
    end
    if (finish) begin
      total_now     <= total_score;
      digits_bcd    <= bcd_ext[31:0];
      rank_position <= (op_r == satk_pkg::OP_COMMIT) ? pos_ext[3:0] : 4'd0;
      entry_value   <= entry_r;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_EXEC))
    else $error("accepted request did not start execution");

  a_chain_exit: assert property (@(posedge clk) disable iff (rst)
    tk[RANK_DEPTH].valid |-> (state == ST_WAIT))
    else $error("commit left the cell row outside a running request");

  a_done_digits: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dig_fin))
    else $error("result given before digit conversion finished");

endmodule
